[rtl/assert_macros.svh]
// Assertion helpers shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRC8FR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRC8FR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/crc8fr_pkg.sv]
package crc8fr_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_POLY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINLEN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFSZ  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK1  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASK2  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MASK3  = 4'd7;

    localparam logic [7:0]  RST_POLY   = 8'h07;
    localparam logic [7:0]  RST_DELIM  = 8'hAA;
    localparam logic [15:0] RST_MINLEN = 16'd4;
    localparam logic [15:0] RST_BUFSZ  = 16'd256;

    // header bytes counted in the length field besides the payload
    localparam logic [16:0] LEN_OVERHEAD = 17'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CMD,
        PH_CRC1,
        PH_PAYLOAD,
        PH_CRC2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_BYTE,
        EV_DONE,
        EV_ERROR
    } ev_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_DELIM,
        ERR_SHORT,
        ERR_LONG,
        ERR_CMD,
        ERR_CRC1,
        ERR_OVERFLOW,
        ERR_CRC2
    } err_t;

    typedef struct packed {
        logic [255:0] cmd_mask;   // bit c set: command code c is valid
        logic [15:0]  buf_size;
        logic [15:0]  min_len;
        logic [7:0]   delim;
        logic [7:0]   poly;
    } cfg_t;

    typedef struct packed {
        ev_t         kind;
        logic [7:0]  out_byte;
        logic [15:0] out_index;
        logic [7:0]  command_type;
        logic [15:0] frame_size;
        err_t        error_code;
    } res_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/crc8fr_cfg_regs.sv]
module crc8fr_cfg_regs
    import crc8fr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_POLY:   cfg_next.poly             = wr_data[7:0];
                REG_DELIM:  cfg_next.delim            = wr_data[7:0];
                REG_MINLEN: cfg_next.min_len          = wr_data[15:0];
                REG_BUFSZ:  cfg_next.buf_size         = wr_data[15:0];
                REG_MASK0:  cfg_next.cmd_mask[63:0]   = wr_data;
                REG_MASK1:  cfg_next.cmd_mask[127:64] = wr_data;
                REG_MASK2:  cfg_next.cmd_mask[191:128] = wr_data;
                REG_MASK3:  cfg_next.cmd_mask[255:192] = wr_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poly     <= RST_POLY;
            cfg_reg.delim    <= RST_DELIM;
            cfg_reg.min_len  <= RST_MINLEN;
            cfg_reg.buf_size <= RST_BUFSZ;
            cfg_reg.cmd_mask <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/crc8fr_deframe.sv]
module crc8fr_deframe
    import crc8fr_pkg::*;
`include "assert_macros.svh"
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       step,      // byte in the input register moves on this edge
    input  logic [7:0] rx_byte,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  hcrc_reg, hcrc_next;
    logic [7:0]  pcrc_reg, pcrc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] pend_reg, pend_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [15:0] len;
    logic [15:0] pend_dec;
    err_t        err;

    assign len      = {rx_byte, pend_reg[7:0]};
    assign pend_dec = pend_reg - 16'd1;

    always_comb begin
        phase_next = phase_reg;
        hcrc_next  = hcrc_reg;
        pcrc_next  = pcrc_reg;
        cmd_next   = cmd_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        err        = ERR_NONE;
        res        = '0;
        res.kind   = EV_NONE;

        case (phase_reg)
            PH_LEN_LO: begin
                pend_next  = {8'd0, rx_byte};
                hcrc_next  = crc8_step(hcrc_reg, rx_byte, cfg.poly);
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pend_next = len;
                if (len < cfg.min_len) begin
                    err = ERR_SHORT;
                end else if ({1'b0, len} > ({1'b0, cfg.buf_size} + LEN_OVERHEAD)) begin
                    err = ERR_LONG;
                end else begin
                    hcrc_next  = crc8_step(hcrc_reg, rx_byte, cfg.poly);
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                pend_next = pend_dec;
                if (cfg.cmd_mask[rx_byte]) begin
                    cmd_next   = rx_byte;
                    hcrc_next  = crc8_step(hcrc_reg, rx_byte, cfg.poly);
                    phase_next = PH_CRC1;
                end else begin
                    err = ERR_CMD;
                end
            end
            PH_CRC1: begin
                pend_next = pend_dec;
                if (hcrc_reg == rx_byte) begin
                    pcrc_next  = crc8_step(pcrc_reg, rx_byte, cfg.poly);
                    cnt_next   = '0;
                    phase_next = PH_PAYLOAD;
                end else begin
                    err = ERR_CRC1;
                end
            end
            PH_PAYLOAD: begin
                pend_next = pend_dec;
                if (cnt_reg < cfg.buf_size) begin
                    res.kind      = EV_BYTE;
                    res.out_byte  = rx_byte;
                    res.out_index = cnt_reg;
                    cnt_next      = cnt_reg + 16'd1;
                    pcrc_next     = crc8_step(pcrc_reg, rx_byte, cfg.poly);
                    if (pend_dec <= 16'd1) begin
                        phase_next = PH_CRC2;
                    end
                end else begin
                    err = ERR_OVERFLOW;
                end
            end
            PH_CRC2: begin
                if (pcrc_reg == rx_byte) begin
                    res.kind         = EV_DONE;
                    res.command_type = cmd_reg;
                    res.frame_size   = cnt_reg;
                    phase_next = PH_HUNT;
                    hcrc_next  = '0;
                    pcrc_next  = '0;
                    cmd_next   = '0;
                    pend_next  = '0;
                    cnt_next   = '0;
                end else begin
                    err = ERR_CRC2;
                end
            end
            default: begin
                if (rx_byte == cfg.delim) begin
                    phase_next = PH_LEN_LO;
                    hcrc_next  = crc8_step(8'd0, rx_byte, cfg.poly);
                    pcrc_next  = '0;
                    cmd_next   = '0;
                    pend_next  = '0;
                    cnt_next   = '0;
                end else begin
                    err = ERR_DELIM;
                end
            end
        endcase

        // any fault drops the frame and goes back to hunting
        if (err != ERR_NONE) begin
            res            = '0;
            res.kind       = EV_ERROR;
            res.error_code = err;
            phase_next = PH_HUNT;
            hcrc_next  = '0;
            pcrc_next  = '0;
            cmd_next   = '0;
            pend_next  = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            hcrc_reg  <= '0;
            pcrc_reg  <= '0;
            cmd_reg   <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            hcrc_reg  <= hcrc_next;
            pcrc_reg  <= pcrc_next;
            cmd_reg   <= cmd_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
        end
    end

    `CRC8FR_ASSERT_NEXT(a_err_resync, aclk, aresetn, step && res.kind == EV_ERROR,
        phase_reg == PH_HUNT && cnt_reg == 16'd0, "error did not return to hunting")
    `CRC8FR_ASSERT_NOW(a_byte_in_payload, aclk, aresetn, step && res.kind == EV_BYTE,
        phase_reg == PH_PAYLOAD && res.error_code == ERR_NONE, "payload byte outside payload")
    `CRC8FR_ASSERT_NEXT(a_done_clears, aclk, aresetn, step && res.kind == EV_DONE,
        phase_reg == PH_HUNT && pend_reg == 16'd0, "completion left frame state")

endmodule

[rtl/crc8fr_result_reg.sv]
module crc8fr_result_reg
    import crc8fr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  res_t                 res,
    output logic                 space,    // register free or emptying this cycle
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {5'd0, res_reg.error_code, res_reg.frame_size,
                       res_reg.command_type, res_reg.out_index, res_reg.out_byte};

endmodule

[rtl/crc8_frame_receiver_core.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata: rx_byte
// m_        out        m_tvalid/m_tready    m_tdata: result fields, m_tuser: event_kind
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One result per received byte, one byte per cycle sustained while m_tready stays high.
// A byte is first held in the input register; the deframer step (CRC-8
// update, length and command checks) then loads the result register.
// Reset (aresetn low, synchronous) restores register defaults and hunting.
// A stalled m_ side holds the result; the input register still takes one
// more byte, then s_tready drops until the result is taken.
module crc8_frame_receiver_core
    import crc8fr_pkg::*;
`include "assert_macros.svh"
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [23:8] out_index,
                                             // [31:24] command_type, [47:32] frame_size,
                                             // [50:48] error_code, [55:51] zero
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] event_kind
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    res_t       res;
    logic       space;
    logic       adv;        // input register transfers into the result register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    assign cfg_ready = 1'b1;

    crc8fr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register: refills in the same cycle it drains
    assign adv      = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
        end
    end

    crc8fr_deframe u_deframe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (adv),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    crc8fr_result_reg u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // every stepped byte shows up as a result on the next cycle
    `CRC8FR_ASSERT_NEXT(a_step_loads, aclk, aresetn, adv, m_tvalid, "stepped byte lost")
    // a held byte is never overwritten by a new transfer
    `CRC8FR_ASSERT_NEXT(a_hold_byte, aclk, aresetn, in_valid_reg && !space,
        in_valid_reg && $stable(in_byte_reg), "pending byte overwritten")

endmodule

[tb/tb_crc8_frame_receiver_core.sv]
`timescale 1ns / 100ps

import crc8fr_pkg::*;

localparam int MAX_REPORTS = 100;

// Tracks the deframer state per received byte and holds the event each byte must produce.
class frame_event_scoreboard;
    // register copies
    logic [7:0]   poly;
    logic [7:0]   delim;
    logic [15:0]  min_len;
    logic [15:0]  buf_size;
    logic [255:0] cmd_mask;
    // frame state
    phase_t       phase;
    logic [7:0]   hdr_crc;
    logic [7:0]   pay_crc;
    logic [7:0]   held_cmd;
    logic [15:0]  pending;
    logic [15:0]  count;

    res_t expected_events[$];
    int   n_errors;
    int   n_checked;

    function new();
        poly     = RST_POLY;
        delim    = RST_DELIM;
        min_len  = RST_MINLEN;
        buf_size = RST_BUFSZ;
        cmd_mask = '0;
        n_errors = 0;
        n_checked = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        phase    = PH_HUNT;
        hdr_crc  = 8'h00;
        pay_crc  = 8'h00;
        held_cmd = 8'h00;
        pending  = 16'h0000;
        count    = 16'h0000;
    endfunction

    // MSB-first CRC-8 byte update, no reflection, implicit x^8
    function logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_POLY:   poly = data[7:0];
            REG_DELIM:  delim = data[7:0];
            REG_MINLEN: min_len = data[15:0];
            REG_BUFSZ:  buf_size = data[15:0];
            REG_MASK0:  cmd_mask[63:0] = data;
            REG_MASK1:  cmd_mask[127:64] = data;
            REG_MASK2:  cmd_mask[191:128] = data;
            REG_MASK3:  cmd_mask[255:192] = data;
            default: ;
        endcase
    endfunction

    function void predict_byte(input logic [7:0] b);
        res_t        r;
        err_t        err;
        logic [16:0] len;
        r = '0;
        r.kind = EV_NONE;
        err = ERR_NONE;
        case (phase)
            PH_LEN_LO: begin
                pending = {8'h00, b};
                hdr_crc = crc8_update(hdr_crc, b);
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len = {1'b0, b, pending[7:0]};
                pending = len[15:0];
                if (len < {1'b0, min_len}) begin
                    err = ERR_SHORT;
                end else if (len > {1'b0, buf_size} + LEN_OVERHEAD) begin
                    err = ERR_LONG;
                end else begin
                    hdr_crc = crc8_update(hdr_crc, b);
                    phase = PH_CMD;
                end
            end
            PH_CMD: begin
                pending = pending - 16'd1;
                if (cmd_mask[b]) begin
                    held_cmd = b;
                    hdr_crc = crc8_update(hdr_crc, b);
                    phase = PH_CRC1;
                end else begin
                    err = ERR_CMD;
                end
            end
            PH_CRC1: begin
                pending = pending - 16'd1;
                if (hdr_crc == b) begin
                    pay_crc = crc8_update(pay_crc, b);
                    count = 16'd0;
                    phase = PH_PAYLOAD;
                end else begin
                    err = ERR_CRC1;
                end
            end
            PH_PAYLOAD: begin
                pending = pending - 16'd1;
                if (count < buf_size) begin
                    r.kind = EV_BYTE;
                    r.out_byte = b;
                    r.out_index = count;
                    count = count + 16'd1;
                    pay_crc = crc8_update(pay_crc, b);
                    if (pending <= 16'd1) begin
                        phase = PH_CRC2;
                    end
                end else begin
                    err = ERR_OVERFLOW;
                end
            end
            PH_CRC2: begin
                if (pay_crc == b) begin
                    r.kind = EV_DONE;
                    r.command_type = held_cmd;
                    r.frame_size = count;
                    clear_frame();
                end else begin
                    err = ERR_CRC2;
                end
            end
            default: begin
                if (b == delim) begin
                    clear_frame();
                    hdr_crc = crc8_update(8'h00, b);
                    phase = PH_LEN_LO;
                end else begin
                    err = ERR_DELIM;
                end
            end
        endcase
        // any fault drops the frame and goes back to hunting
        if (err != ERR_NONE) begin
            r = '0;
            r.kind = EV_ERROR;
            r.error_code = err;
            clear_frame();
        end
        expected_events.push_back(r);
    endfunction

    function int n_waiting();
        return expected_events.size();
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                     n_checked, what, got, want);
        end
    endtask

    task check_result(input logic [M_TUSER_W-1:0] kind_bits, input logic [M_TDATA_W-1:0] d);
        res_t e;
        n_checked++;
        if (expected_events.size() == 0) begin
            report_mismatch("unexpected result transfer", d, 64'h0);
            return;
        end
        e = expected_events.pop_front();
        if (kind_bits !== e.kind)           report_mismatch("event_kind", kind_bits, e.kind);
        if (d[7:0] !== e.out_byte)          report_mismatch("out_byte", d[7:0], e.out_byte);
        if (d[23:8] !== e.out_index)        report_mismatch("out_index", d[23:8], e.out_index);
        if (d[31:24] !== e.command_type)    report_mismatch("command_type", d[31:24], e.command_type);
        if (d[47:32] !== e.frame_size)      report_mismatch("frame_size", d[47:32], e.frame_size);
        if (d[50:48] !== e.error_code)      report_mismatch("error_code", d[50:48], e.error_code);
        if (d[55:51] !== 5'd0)              report_mismatch("tdata pad", d[55:51], 64'h0);
    endtask
endclass

module tb_crc8_frame_receiver_core;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 120;

    // how a generated frame is broken, if at all
    typedef enum {
        FLT_NONE,
        FLT_SHORT,
        FLT_LONG,
        FLT_CMD,
        FLT_CRC1,
        FLT_CRC2,
        FLT_TRUNC
    } fault_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    frame_event_scoreboard sb;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_items      = 0;
    int quiet_cycles = 0;
    int hold_ticket  = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    crc8_frame_receiver_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receive side: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
        end
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.predict_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // leaves s_tvalid high after the transfer; the next call or quiesce() takes it over
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        n_items++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.n_waiting() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic write_masks(input logic [63:0] m);
        write_reg(REG_MASK0, m);
        write_reg(REG_MASK1, m);
        write_reg(REG_MASK2, m);
        write_reg(REG_MASK3, m);
    endtask

    // command code whose mask bit matches want_valid, when one can be found
    function automatic logic [7:0] pick_cmd(input bit want_valid);
        logic [7:0] c;
        c = 8'($urandom);
        for (int i = 0; i < 64 && sb.cmd_mask[c] !== want_valid; i++) begin
            c = 8'($urandom);
        end
        return c;
    endfunction

    // delimiter, length, command, CRC1, payload, CRC2; stops early where the fault ends it
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input int n_pay,
                              input fault_t flt);
        logic [7:0] crc;
        logic [7:0] pb;
        crc = sb.crc8_update(8'h00, sb.delim);
        send_byte(sb.delim);
        send_byte(len[7:0]);
        crc = sb.crc8_update(crc, len[7:0]);
        send_byte(len[15:8]);
        if (flt == FLT_SHORT || flt == FLT_LONG) return;
        crc = sb.crc8_update(crc, len[15:8]);
        send_byte(cmd);
        if (flt == FLT_CMD) return;
        crc = sb.crc8_update(crc, cmd);
        if (flt == FLT_CRC1) begin
            send_byte(crc ^ (8'h01 << $urandom_range(7, 0)));
            return;
        end
        send_byte(crc);
        crc = sb.crc8_update(8'h00, crc);
        for (int k = 0; k < n_pay; k++) begin
            pb = 8'($urandom);
            send_byte(pb);
            crc = sb.crc8_update(crc, pb);
        end
        if (flt == FLT_TRUNC) return;
        if (flt == FLT_CRC2) begin
            send_byte(crc ^ (8'h01 << $urandom_range(7, 0)));
        end else begin
            send_byte(crc);
        end
    endtask

    task automatic random_frame();
        int r;
        int lo_n;
        int hi_n;
        int n;
        int lo_len;
        int hi_len;
        logic [15:0] len;
        r = $urandom_range(99, 0);
        lo_n = (sb.min_len > 16'd3) ? int'(sb.min_len) - 3 : 1;
        hi_n = (int'(sb.buf_size) < lo_n + 11) ? int'(sb.buf_size) : lo_n + 11;
        if ($urandom_range(19, 0) == 0) begin
            hi_n = (int'(sb.buf_size) < lo_n + 300) ? int'(sb.buf_size) : lo_n + 300;
        end
        if (hi_n < lo_n) hi_n = lo_n;
        n = $urandom_range(hi_n, lo_n);
        len = 16'(n + 3);
        if (r < 60) begin
            send_frame(pick_cmd(1'b1), len, n, FLT_NONE);
        end else if (r < 68 && sb.min_len != 16'd0) begin
            send_frame(pick_cmd(1'b1), 16'($urandom_range(int'(sb.min_len) - 1, 0)), 0, FLT_SHORT);
        end else if (r < 74 && sb.buf_size <= 16'd65531) begin
            lo_len = int'(sb.buf_size) + 4;
            hi_len = (lo_len + 40 > 65535) ? 65535 : lo_len + 40;
            if ($urandom_range(3, 0) == 0) hi_len = 65535;
            send_frame(pick_cmd(1'b1), 16'($urandom_range(hi_len, lo_len)), 0, FLT_LONG);
        end else if (r < 80) begin
            send_frame(pick_cmd(1'b0), len, n, FLT_CMD);
        end else if (r < 85) begin
            send_frame(pick_cmd(1'b1), len, n, FLT_CRC1);
        end else if (r < 90) begin
            send_frame(pick_cmd(1'b1), len, n, FLT_CRC2);
        end else if (r < 94) begin
            send_frame(pick_cmd(1'b1), len, $urandom_range(n - 1, 0), FLT_TRUNC);
        end else if (r < 97 || sb.min_len > 16'd3) begin
            // line noise, now and then a stray delimiter
            repeat ($urandom_range(4, 1)) begin
                send_byte(($urandom_range(3, 0) == 0) ? sb.delim : 8'($urandom));
            end
        end else begin
            // length below 4: below 3 the pending count wraps, frame runs into overflow
            n = (int'(sb.buf_size) + 1 < 30) ? int'(sb.buf_size) + 1 : 30;
            send_frame(pick_cmd(1'b1), 16'($urandom_range(3, int'(sb.min_len))), n, FLT_TRUNC);
        end
    endtask

    task automatic random_config();
        logic [63:0] d;
        int r;
        d = {$urandom, $urandom};
        write_reg(REG_POLY, d);
        d = {$urandom, $urandom};
        write_reg(REG_DELIM, d);
        d = {$urandom, $urandom};
        r = $urandom_range(99, 0);
        if (r < 60)      d[15:0] = 16'd4;
        else if (r < 80) d[15:0] = 16'($urandom_range(3, 0));
        else             d[15:0] = 16'($urandom_range(20, 5));
        write_reg(REG_MINLEN, d);
        d = {$urandom, $urandom};
        r = $urandom_range(99, 0);
        if (r < 70)      d[15:0] = 16'($urandom_range(24, 1));
        else if (r < 85) d[15:0] = 16'd256;
        else if (r < 95) d[15:0] = 16'($urandom_range(400, 25));
        else             d[15:0] = 16'd65532;
        write_reg(REG_BUFSZ, d);
        for (int i = 0; i < 4; i++) begin
            r = $urandom_range(99, 0);
            if (r < 40)      d = '1;
            else if (r < 55) d = '0;
            else             d = {$urandom, $urandom};
            write_reg(REG_MASK0 + CFG_IDX_W'(i), d);
        end
        // indexes past the last register must be ignored
        if ($urandom_range(99, 0) < 30) begin
            write_reg(REG_MASK3 + 4'd1 + 4'($urandom_range(7, 0)), {$urandom, $urandom});
        end
    endtask

    initial begin
        int base;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings with nothing valid as a command, then every command valid
        snd_idle_pct = 9;
        rcv_idle_pct = 87;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(pick_cmd(1'b0), 16'd4, 1, FLT_CMD);
        quiesce();
        write_masks('1);
        send_frame(8'hFF, 16'd4, 1, FLT_NONE);
        send_frame(8'h00, 16'd3, 0, FLT_SHORT);
        send_frame(8'h00, 16'd260, 0, FLT_LONG);
        send_frame(8'h80, 16'd4, 1, FLT_CRC1);
        send_frame(8'h40, 16'd4, 1, FLT_CRC2);

        // upper extremes of lengths, zero polynomial and delimiter
        quiesce();
        write_reg(REG_POLY, 64'h0);
        write_reg(REG_DELIM, 64'h0);
        write_reg(REG_MINLEN, 64'hFFFF);
        write_reg(REG_BUFSZ, 64'd65532);
        write_masks('0);
        send_frame(8'h3C, 16'hFFFF, 0, FLT_CMD);

        // length 2 with minimum 0, then buffer shrunk in mid-payload -> overflow
        quiesce();
        write_reg(REG_POLY, 64'hFF);
        write_reg(REG_DELIM, 64'hFF);
        write_reg(REG_MINLEN, 64'h0);
        write_reg(REG_BUFSZ, 64'd2);
        write_masks('1);
        send_frame(8'hC3, 16'd2, 1, FLT_TRUNC);
        quiesce();
        write_reg(REG_BUFSZ, 64'd1);
        send_byte(8'($urandom));

        // random part, three back-pressure regimes
        for (int g = 0; g < 3; g++) begin
            case (g)
                0: begin
                    snd_idle_pct = 9;
                    rcv_idle_pct = 87;
                end
                1: begin
                    snd_idle_pct = 87;
                    rcv_idle_pct = 9;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < 4; p++) begin
                quiesce();
                random_config();
                if (g == 2 && p == 0) begin
                    // receiver stalls, sender keeps pushing until input backs up
                    hold_ticket++;
                    base = n_items;
                    while (n_items - base < 40) random_frame();
                end
                base = n_items;
                while (n_items - base < PHASE_ITEMS) random_frame();
            end
        end

        quiesce();
        repeat (8) @(posedge aclk);
        if (sb.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
